// ===== hdl/sgm_pkg.sv =====
// Shared types, field widths and register codes of the smoothed gradient magnitude block.
// No dependencies; every other file of the block imports this package.
package sgm_pkg;

  localparam int PIX_W      = 16;
  localparam int MAG_W      = 17;
  localparam int GRAD_W     = 17;
  localparam int DIM_W      = 12;
  localparam int TAP_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int ROOT_STEPS = 17;
  localparam int KERNEL_SIZE = 5;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_OUTER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_INNER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_CENTER   = 3'd4;

  // Neighbours of the output pixel whose smoothed values are needed.
  localparam logic [1:0] PT_RIGHT = 2'd0;
  localparam logic [1:0] PT_LEFT  = 2'd1;
  localparam logic [1:0] PT_BELOW = 2'd2;
  localparam logic [1:0] PT_ABOVE = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       rd;
    logic [1:0] point;
    logic [2:0] dy;
    logic [2:0] dx;
    logic       grad;
    logic       root_init;
    logic       root_step;
    logic       emit;
  } sgm_cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic drain_ok;
    logic gx_en;
    logic gy_en;
    logic out_free;
  } sgm_status_t;

  // Kernel weight at tap position d of 0..4, the centre being position 2.
  function automatic logic [TAP_W-1:0] tap_pick(input logic [2:0] d,
                                                input logic [TAP_W-1:0] t_outer,
                                                input logic [TAP_W-1:0] t_inner,
                                                input logic [TAP_W-1:0] t_center);
    logic [TAP_W-1:0] t;
    case (d)
      3'd0, 3'd4: t = t_outer;
      3'd1, 3'd3: t = t_inner;
      default:    t = t_center;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/sgm_in_if.sv =====
// Input channel of the smoothed gradient magnitude block: pixel and drain items.
// Depends on sgm_pkg for the field widths.
interface sgm_in_if import sgm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, func, pixel, input ready);
  modport sink (input valid, func, pixel, output ready);
endinterface

// ===== hdl/sgm_out_if.sv =====
// Result channel of the smoothed gradient magnitude block.
// Depends on sgm_pkg for the field widths.
interface sgm_out_if import sgm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MAG_W-1:0]         magnitude;
  logic signed [GRAD_W-1:0] grad_col;
  logic signed [GRAD_W-1:0] grad_row;
  logic                     end_of_row;
  logic                     end_of_frame;

  modport source (output valid, magnitude, grad_col, grad_row, end_of_row, end_of_frame,
                  input ready);
  modport sink (input valid, magnitude, grad_col, grad_row, end_of_row, end_of_frame,
                output ready);
endinterface

// ===== hdl/sgm_ctrl.sv =====
// Sequencer of the smoothed gradient magnitude block: steps one item through the
// line store reads, gradient and square root phases. Depends on sgm_pkg.
module sgm_ctrl import sgm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_func,
  output logic        in_ready,
  input  sgm_status_t status,
  output sgm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE, CHECK, READ, FLUSH, GRAD, ROOT_INIT, ROOT, EMIT
  } state_t;

  state_t     state;
  logic       is_drain;
  logic [1:0] point;
  logic [2:0] dy;
  logic [2:0] dx;
  logic [4:0] cnt;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.accept    = in_valid && (state == IDLE);
    cmd.rd        = (state == READ);
    cmd.point     = point;
    cmd.dy        = dy;
    cmd.dx        = dx;
    cmd.grad      = (state == GRAD);
    cmd.root_init = (state == ROOT_INIT);
    cmd.root_step = (state == ROOT);
    cmd.emit      = (state == EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      is_drain <= 1'b0;
      point    <= PT_RIGHT;
      dy       <= '0;
      dx       <= '0;
      cnt      <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            is_drain <= in_func;
            state    <= CHECK;
          end
        end
        CHECK: begin
          dy <= '0;
          dx <= '0;
          if (is_drain ? status.drain_ok : status.emit_ok) begin
            if (status.gx_en) begin
              point <= PT_RIGHT;
              state <= READ;
            end else if (status.gy_en) begin
              point <= PT_BELOW;
              state <= READ;
            end else begin
              cnt   <= 5'd2;
              state <= FLUSH;
            end
          end else begin
            state <= IDLE;
          end
        end
        READ: begin
          if (dx == 3'd4) begin
            dx <= '0;
            if (dy == 3'd4) begin
              dy <= '0;
              if (point == PT_RIGHT) begin
                point <= PT_LEFT;
              end else if (point == PT_BELOW) begin
                point <= PT_ABOVE;
              end else if (point == PT_LEFT && status.gy_en) begin
                point <= PT_BELOW;
              end else begin
                cnt   <= 5'd2;
                state <= FLUSH;
              end
            end else begin
              dy <= dy + 3'd1;
            end
          end else begin
            dx <= dx + 3'd1;
          end
        end
        FLUSH: begin
          if (cnt == '0) begin
            state <= GRAD;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        GRAD: begin
          state <= ROOT_INIT;
        end
        ROOT_INIT: begin
          cnt   <= 5'(ROOT_STEPS - 1);
          state <= ROOT;
        end
        ROOT: begin
          if (cnt == '0) begin
            state <= EMIT;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        EMIT: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sgm_datapath.sv =====
// Datapath of the smoothed gradient magnitude block: configuration registers, raw line
// store, position counters, smoothing MAC, gradients, square root and result register.
// Depends on sgm_pkg.
module sgm_datapath import sgm_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_func,
  input  logic [PIX_W-1:0]         in_pixel,
  input  logic                     out_ready,
  input  sgm_cmd_t                 cmd,
  output sgm_status_t              status,
  output logic                     out_valid,
  output logic [MAG_W-1:0]         magnitude,
  output logic signed [GRAD_W-1:0] grad_col,
  output logic signed [GRAD_W-1:0] grad_row,
  output logic                     end_of_row,
  output logic                     end_of_frame
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WW      = CW + 1;
  localparam int LW      = $clog2(3 * MAX_WIDTH + 5);
  localparam int AW      = CW + 3;
  localparam int DEPTH   = 8 * (2 ** CW);
  localparam int RESET_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

  // Configuration registers and the geometry and taps latched for the current frame.
  logic [DIM_W-1:0] reg_width, reg_height;
  logic [TAP_W-1:0] reg_outer, reg_inner, reg_center;
  logic [WW-1:0]    cur_w;
  logic [DIM_W-1:0] cur_h;
  logic [TAP_W-1:0] t_outer, t_inner, t_center;
  logic [LW-1:0]    lat1;

  logic [CW-1:0]    in_col, out_col;
  logic [DIM_W-1:0] in_row, out_row;
  logic [LW-1:0]    pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= DIM_W'(640);
      reg_height <= DIM_W'(480);
      reg_outer  <= TAP_W'(14);
      reg_inner  <= TAP_W'(63);
      reg_center <= TAP_W'(102);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  reg_width  <= cfg_data;
        REG_IMAGE_HEIGHT: reg_height <= cfg_data;
        REG_TAP_OUTER:    reg_outer  <= cfg_data[TAP_W-1:0];
        REG_TAP_INNER:    reg_inner  <= cfg_data[TAP_W-1:0];
        REG_TAP_CENTER:   reg_center <= cfg_data[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame start and the counters as seen by an incoming pixel.
  logic             frame_start;
  logic [31:0]      w_ext;
  logic [WW-1:0]    w_clamp, base_w;
  logic [DIM_W-1:0] h_clamp, base_row;
  logic [CW-1:0]    base_col;
  logic [LW-1:0]    base_pend;
  logic [WW-1:0]    col_inc;
  logic             col_wrap;
  logic             pix_acc;

  always_comb begin
    frame_start = ((in_row == '0) && (in_col == '0)) || (in_row >= cur_h);
    w_ext       = 32'(reg_width);
    if (w_ext < 32'd3) begin
      w_clamp = WW'(3);
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(w_ext);
    end
    h_clamp   = (reg_height < DIM_W'(3)) ? DIM_W'(3) : reg_height;
    base_w    = frame_start ? w_clamp : cur_w;
    base_col  = frame_start ? '0 : in_col;
    base_row  = frame_start ? '0 : in_row;
    base_pend = frame_start ? '0 : pending;
    col_inc   = {1'b0, base_col} + WW'(1);
    col_wrap  = (col_inc >= base_w);
    pix_acc   = cmd.accept && !in_func;
  end

  logic out_last_col;
  assign out_last_col = ({1'b0, out_col} == (cur_w - WW'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_w    <= WW'(RESET_W);
      cur_h    <= DIM_W'(480);
      t_outer  <= TAP_W'(14);
      t_inner  <= TAP_W'(63);
      t_center <= TAP_W'(102);
      lat1     <= LW'(3 * RESET_W + 4);
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      pending  <= '0;
    end else if (pix_acc) begin
      if (frame_start) begin
        cur_w    <= w_clamp;
        cur_h    <= h_clamp;
        t_outer  <= reg_outer;
        t_inner  <= reg_inner;
        t_center <= reg_center;
        lat1     <= LW'({w_clamp, 1'b0}) + LW'(w_clamp) + LW'(4);
        out_col  <= '0;
        out_row  <= '0;
      end
      in_col  <= col_wrap ? '0 : col_inc[CW-1:0];
      in_row  <= base_row + DIM_W'(col_wrap);
      pending <= base_pend + LW'(1);
    end else if (cmd.emit) begin
      pending <= pending - LW'(1);
      if (out_last_col) begin
        out_col <= '0;
        out_row <= out_row + DIM_W'(1);
      end else begin
        out_col <= out_col + CW'(1);
      end
    end
  end

  // Line store: eight rows, one write and one registered read per cycle.
  function automatic logic [14:0] reflect(input logic [14:0] i, input logic [14:0] n);
    logic [14:0] a;
    a = i[14] ? (15'd0 - i) : i;
    if (a >= n) begin
      a = {n[13:0], 1'b0} - 15'd2 - a;
    end
    return a;
  endfunction

  logic [14:0]   rr, cc, ri, ci, rref, cref;
  logic [AW-1:0] raddr;
  logic [PIX_W-1:0] line_mem [DEPTH];
  logic [PIX_W-1:0] rdata;

  always_comb begin
    rr = 15'(out_row);
    cc = 15'(out_col);
    case (cmd.point)
      PT_RIGHT: cc = 15'(out_col) + 15'd1;
      PT_LEFT:  cc = 15'(out_col) - 15'd1;
      PT_BELOW: rr = 15'(out_row) + 15'd1;
      default:  rr = 15'(out_row) - 15'd1;
    endcase
    ri    = rr + 15'(cmd.dy) - 15'd2;
    ci    = cc + 15'(cmd.dx) - 15'd2;
    rref  = reflect(ri, 15'(cur_h));
    cref  = reflect(ci, 15'(cur_w));
    raddr = {rref[2:0], cref[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      line_mem[{base_row[2:0], base_col}] <= in_pixel;
    end
    rdata <= line_mem[raddr];
  end

  // Smoothing: horizontal sums in the first stage, vertical sum in the second,
  // rounding and saturation in the third.
  logic       s1_valid, s2_valid, s3_valid;
  logic [2:0] s1_dx, s1_dy, s2_dy;
  logic [1:0] s1_point, s2_point, s3_point;
  logic [27:0] hacc, h_fin, hsum;
  logic [24:0] prod1;
  logic [36:0] prod2;
  logic [39:0] vacc, vsum;
  logic [40:0] vround;
  logic [PIX_W-1:0] sm_val;
  logic [PIX_W-1:0] smv [4];

  always_comb begin
    prod1  = tap_pick(s1_dx, t_outer, t_inner, t_center) * rdata;
    hsum   = ((s1_dx == 3'd0) ? 28'd0 : hacc) + 28'(prod1);
    prod2  = tap_pick(s2_dy, t_outer, t_inner, t_center) * h_fin;
    vsum   = ((s2_dy == 3'd0) ? 40'd0 : vacc) + 40'(prod2);
    vround = 41'(vacc) + 41'd32768;
    sm_val = (vround[40:16] > 25'd65535) ? 16'hFFFF : vround[31:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd;
      s2_valid <= s1_valid && (s1_dx == 3'd4);
      s3_valid <= s2_valid && (s2_dy == 3'd4);
    end
    s1_dx    <= cmd.dx;
    s1_dy    <= cmd.dy;
    s1_point <= cmd.point;
    if (s1_valid) begin
      hacc <= hsum;
    end
    if (s1_valid && (s1_dx == 3'd4)) begin
      h_fin    <= hsum;
      s2_dy    <= s1_dy;
      s2_point <= s1_point;
    end
    if (s2_valid) begin
      vacc     <= vsum;
      s3_point <= s2_point;
    end
    if (s3_valid) begin
      smv[s3_point] <= sm_val;
    end
  end

  // Gradients, squares and the bit-pair square root.
  logic gx_en, gy_en;
  logic signed [GRAD_W-1:0] gx, gy, gx_r, gy_r;
  logic signed [33:0] gx_sq, gy_sq;
  logic [32:0] sqx, sqy;
  logic [33:0] rad;
  logic [18:0] rem, rem_sh, trial;
  logic [MAG_W-1:0] root;
  logic root_ge;

  always_comb begin
    gx_en   = (out_col != '0) && !out_last_col;
    gy_en   = (out_row != '0) && (out_row != (cur_h - DIM_W'(1)));
    gx      = gx_en ? ($signed({1'b0, smv[PT_RIGHT]}) - $signed({1'b0, smv[PT_LEFT]}))
                    : '0;
    gy      = gy_en ? ($signed({1'b0, smv[PT_BELOW]}) - $signed({1'b0, smv[PT_ABOVE]}))
                    : '0;
    gx_sq   = gx * gx;
    gy_sq   = gy * gy;
    rem_sh  = {rem[16:0], rad[33:32]};
    trial   = {root[16:0], 2'b01};
    root_ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx_r <= gx;
      gy_r <= gy;
      sqx  <= gx_sq[32:0];
      sqy  <= gy_sq[32:0];
    end
    if (cmd.root_init) begin
      rad  <= 34'(sqx) + 34'(sqy);
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[31:0], 2'b00};
      rem  <= root_ge ? (rem_sh - trial) : rem_sh;
      root <= {root[15:0], root_ge};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      magnitude    <= root;
      grad_col     <= gx_r;
      grad_row     <= gy_r;
      end_of_row   <= out_last_col;
      end_of_frame <= out_last_col && (out_row == (cur_h - DIM_W'(1)));
    end
  end

  always_comb begin
    status.emit_ok  = (pending >= lat1) && (out_row < cur_h);
    status.drain_ok = (in_row >= cur_h) && (out_row < cur_h);
    status.gx_en    = gx_en;
    status.gy_en    = gy_en;
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ===== hdl/smoothed_gradient_magnitude_core.sv =====
// Smoothed gradient magnitude core. Pixels arrive in row order and are written into a line
// store of eight rows of MAX_WIDTH 16-bit entries; the frame geometry and the three kernel
// taps are latched at the first pixel of each frame, so register writes act on the next
// frame. Each result is the output of a 5x5 separable smoothing (reflected borders, rounded
// and saturated to 16 bits) differenced across columns and rows, with the floor of the
// root of the sum of squares; border gradients are zero. Results trail the input by
// 3*width+3 pixels, and drain items release the remaining ones after the last pixel. Items
// are handled one at a time: an item that yields no result returns the block to idle after
// its check, and the time taken by one that yields a result is set by the single read port
// of the line store, which supplies the 25 raw pixels of each of up to four smoothed
// neighbours one per cycle, followed by the 17-step square root. A finished result waits
// in the output register while the next item is transferred in. Reads of line store rows
// that the current frame has not yet written are undefined.
module smoothed_gradient_magnitude_core import sgm_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sgm_in_if.sink                pixels,
  sgm_out_if.source             results
);

  sgm_cmd_t    cmd;
  sgm_status_t status;

  // The sequencer decides when an input transfer takes place and what follows it.
  sgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_func  (pixels.func),
    .in_ready (pixels.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds all storage and arithmetic, including the output register.
  sgm_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_func      (pixels.func),
    .in_pixel     (pixels.pixel),
    .out_ready    (results.ready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (results.valid),
    .magnitude    (results.magnitude),
    .grad_col     (results.grad_col),
    .grad_row     (results.grad_row),
    .end_of_row   (results.end_of_row),
    .end_of_frame (results.end_of_frame)
  );

endmodule
